@@ sv/vdm_pkg.sv @@
// Shared types and constants of the vector distance block.
// Used by the controller, the datapath, the top level and the checker.
package vdm_pkg;

  localparam int unsigned ElemBits   = 16;
  localparam int unsigned AccBits    = 48;
  localparam int unsigned DistBits   = 32;
  localparam int unsigned MaxDimDef  = 1024;
  localparam logic [16:0] OneQ16     = 17'd65536;

  // metric_mode codes
  localparam logic [1:0] MODE_L2  = 2'd0;
  localparam logic [1:0] MODE_COS = 2'd1;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD_L2,
    CMD_LOAD_A,
    CMD_NORM,
    CMD_SQRT_INIT,
    CMD_SQRT_STEP,
    CMD_SAVE_A,
    CMD_SAVE_B,
    CMD_MUL,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_RES_L2,
    CMD_RES_COS,
    CMD_RES_ZERO,
    CMD_RES_BAD
  } cmd_op_e;

  typedef struct packed {
    logic    take;  // request accepted this cycle
    cmd_op_e op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       norm_zero;
    logic       norm_ok;
    logic       iter_last;
    logic       out_free;
  } sts_t;

endpackage

@@ sv/vdm_datapath.sv @@
// Datapath of the vector distance block: product stage, accumulators,
// shared square-root / divide registers and the result register. Uses vdm_pkg.
module vdm_datapath #(
  parameter int unsigned MaxDim = vdm_pkg::MaxDimDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  vdm_pkg::cmd_t                        cmd_i,
  output vdm_pkg::sts_t                        sts_o,
  input  logic signed [vdm_pkg::ElemBits-1:0]  elem_a_i,
  input  logic signed [vdm_pkg::ElemBits-1:0]  elem_b_i,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_data_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [vdm_pkg::DistBits-1:0]         distance_o,
  output logic [1:0]                           status_o
);

  localparam int unsigned CntW = $clog2(MaxDim + 1);
  localparam int unsigned EB   = vdm_pkg::ElemBits;
  localparam int unsigned AB   = vdm_pkg::AccBits;

  // product stage
  logic signed [EB:0]       a_ext, b_ext, d_ext;
  logic signed [2*EB+1:0]   dd_w;
  logic signed [2*EB-1:0]   ab_w, aa_w, bb_w;
  logic [AB-1:0]            p_dd_q, p_ab_q, p_aa_q, p_bb_q;
  logic                     p_vld_q;
  logic [CntW-1:0]          cnt_q;
  logic                     room;

  // accumulators
  logic [AB-1:0] diff_q, dot_q, na_q, nb_q;
  logic [1:0]    mode_q;
  logic          clr;

  // iterative unit registers
  logic [63:0] x_q, r_q, rem_q;
  logic [4:0]  k_q, ka_q, kb_q, it_q;
  logic [31:0] ra_q, rb_q;
  logic [5:0]  s_q;
  logic [61:0] prod_q;
  logic [45:0] den_q;
  logic [19:0] q_q;
  logic        neg_q, big_q;

  logic [63:0] sbit, stry;
  logic [65:0] dsh;
  logic [AB-1:0] mag;
  logic [63:0] lim;
  logic [63:0] rab_w;
  logic [32:0] rr;
  logic [16:0] qc;

  // result register
  logic                  ov_q;
  logic [31:0]           dist_q, dist_d;
  logic [1:0]            st_q, st_d;
  logic                  res_ld;

  assign a_ext = {elem_a_i[EB-1], elem_a_i};
  assign b_ext = {elem_b_i[EB-1], elem_b_i};
  assign d_ext = a_ext - b_ext;
  assign dd_w  = d_ext * d_ext;
  assign ab_w  = elem_a_i * elem_b_i;
  assign aa_w  = elem_a_i * elem_a_i;
  assign bb_w  = elem_b_i * elem_b_i;
  assign room  = cnt_q < CntW'(MaxDim);

  assign clr = (cmd_i.op == vdm_pkg::CMD_RES_L2) || (cmd_i.op == vdm_pkg::CMD_RES_COS) ||
               (cmd_i.op == vdm_pkg::CMD_RES_ZERO) || (cmd_i.op == vdm_pkg::CMD_RES_BAD);
  assign res_ld = clr;

  always_ff @(posedge clk_i) begin
    p_dd_q <= AB'(dd_w);
    p_ab_q <= AB'(ab_w);
    p_aa_q <= AB'(aa_w);
    p_bb_q <= AB'(bb_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      cnt_q   <= '0;
      diff_q  <= '0;
      dot_q   <= '0;
      na_q    <= '0;
      nb_q    <= '0;
      mode_q  <= vdm_pkg::MODE_L2;
    end else begin
      p_vld_q <= cmd_i.take && room;
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (clr) begin
        cnt_q  <= '0;
        diff_q <= '0;
        dot_q  <= '0;
        na_q   <= '0;
        nb_q   <= '0;
      end else begin
        if (cmd_i.take && room) begin
          cnt_q <= cnt_q + CntW'(1);
        end
        if (p_vld_q) begin
          diff_q <= diff_q + p_dd_q;
          dot_q  <= dot_q + p_ab_q;
          na_q   <= na_q + p_aa_q;
          nb_q   <= nb_q + p_bb_q;
        end
      end
    end
  end

  // square root step: bit walks down in powers of four
  assign sbit = 64'(1) << {it_q, 1'b0};
  assign stry = r_q + sbit;
  // restoring divide step
  assign dsh  = 66'(den_q) << it_q;
  assign mag  = dot_q[AB-1] ? (AB'(0) - dot_q) : dot_q;
  assign lim  = 64'(1) << (6'd62 - s_q);
  // product of the two roots, full width
  assign rab_w = ra_q * rb_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      vdm_pkg::CMD_LOAD_L2: begin
        x_q  <= {8'b0, diff_q, 8'b0};
        r_q  <= '0;
        it_q <= 5'd31;
      end
      vdm_pkg::CMD_LOAD_A: begin
        x_q <= 64'(na_q);
        k_q <= '0;
      end
      vdm_pkg::CMD_NORM: begin
        if (x_q[63:60] == 4'd0) begin
          x_q <= {x_q[61:0], 2'b00};
          k_q <= k_q + 5'd1;
        end
      end
      vdm_pkg::CMD_SQRT_INIT: begin
        r_q  <= '0;
        it_q <= 5'd31;
      end
      vdm_pkg::CMD_SQRT_STEP: begin
        if (x_q >= stry) begin
          x_q <= x_q - stry;
          r_q <= (r_q >> 1) + sbit;
        end else begin
          r_q <= r_q >> 1;
        end
        it_q <= it_q - 5'd1;
      end
      vdm_pkg::CMD_SAVE_A: begin
        ra_q <= r_q[31:0];
        ka_q <= k_q;
        x_q  <= 64'(nb_q);
        k_q  <= '0;
      end
      vdm_pkg::CMD_SAVE_B: begin
        rb_q <= r_q[31:0];
        kb_q <= k_q;
      end
      vdm_pkg::CMD_MUL: begin
        prod_q <= rab_w[61:0];
        s_q    <= 6'(ka_q) + 6'(kb_q);
      end
      vdm_pkg::CMD_DIV_INIT: begin
        den_q <= prod_q[61:16];
        neg_q <= dot_q[AB-1];
        big_q <= 64'(mag) > lim;
        rem_q <= (64'(mag) << s_q) + 64'(prod_q[61:17]);
        q_q   <= '0;
        it_q  <= 5'd19;
      end
      vdm_pkg::CMD_DIV_STEP: begin
        if ({2'b00, rem_q} >= dsh) begin
          rem_q <= rem_q - dsh[63:0];
          q_q   <= {q_q[18:0], 1'b1};
        end else begin
          q_q   <= {q_q[18:0], 1'b0};
        end
        it_q <= it_q - 5'd1;
      end
      default: ;
    endcase
  end

  // result formatting
  assign rr = {1'b0, r_q[31:0]} + 33'(x_q > r_q);
  assign qc = (big_q || (q_q > 20'(vdm_pkg::OneQ16))) ? vdm_pkg::OneQ16 : q_q[16:0];

  always_comb begin
    dist_d = '1;
    st_d   = vdm_pkg::ST_OK;
    case (cmd_i.op)
      vdm_pkg::CMD_RES_L2:   dist_d = rr[32] ? '1 : rr[31:0];
      vdm_pkg::CMD_RES_COS:  dist_d = neg_q ? 32'(vdm_pkg::OneQ16) + 32'(qc)
                                            : 32'(vdm_pkg::OneQ16) - 32'(qc);
      vdm_pkg::CMD_RES_ZERO: st_d = vdm_pkg::ST_ZERO;
      vdm_pkg::CMD_RES_BAD:  st_d = vdm_pkg::ST_BAD;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (res_ld) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ld) begin
      dist_q <= dist_d;
      st_q   <= st_d;
    end
  end

  assign out_valid_o = ov_q;
  assign distance_o  = dist_q;
  assign status_o    = st_q;

  assign sts_o.mode      = mode_q;
  assign sts_o.norm_zero = (na_q == '0) || (nb_q == '0);
  assign sts_o.norm_ok   = x_q[63:60] != 4'd0;
  assign sts_o.iter_last = it_q == 5'd0;
  assign sts_o.out_free  = !ov_q || !out_stall_i;

endmodule

@@ sv/vdm_ctrl.sv @@
// Sequencer of the vector distance block: accepts pairs, then steps the
// shared root and divide unit at vector end. Uses vdm_pkg.
module vdm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_elem_i,
  output logic          in_stall_o,
  input  vdm_pkg::sts_t sts_i,
  output vdm_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_DISPATCH, S_SQRT_L2, S_NORM_A, S_SQRT_A, S_SAVE_A,
    S_NORM_B, S_SQRT_B, S_SAVE_B, S_MUL, S_DIV_INIT, S_DIV, S_FINISH
  } state_e;

  state_e           state_q, state_d;
  vdm_pkg::cmd_op_e kind_q, kind_d;

  assign in_stall_o = state_q != S_IDLE;
  assign cmd_o.take = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    cmd_o.op  = vdm_pkg::CMD_NONE;
    case (state_q)
      S_IDLE:     if (in_valid_i && last_elem_i) state_d = S_ACC;
      S_ACC:      state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (sts_i.mode)
          vdm_pkg::MODE_L2: begin
            cmd_o.op = vdm_pkg::CMD_LOAD_L2;
            state_d  = S_SQRT_L2;
          end
          vdm_pkg::MODE_COS: begin
            if (sts_i.norm_zero) begin
              kind_d  = vdm_pkg::CMD_RES_ZERO;
              state_d = S_FINISH;
            end else begin
              cmd_o.op = vdm_pkg::CMD_LOAD_A;
              state_d  = S_NORM_A;
            end
          end
          default: begin
            kind_d  = vdm_pkg::CMD_RES_BAD;
            state_d = S_FINISH;
          end
        endcase
      end
      S_SQRT_L2: begin
        cmd_o.op = vdm_pkg::CMD_SQRT_STEP;
        if (sts_i.iter_last) begin
          kind_d  = vdm_pkg::CMD_RES_L2;
          state_d = S_FINISH;
        end
      end
      S_NORM_A, S_NORM_B: begin
        if (sts_i.norm_ok) begin
          cmd_o.op = vdm_pkg::CMD_SQRT_INIT;
          state_d  = (state_q == S_NORM_A) ? S_SQRT_A : S_SQRT_B;
        end else begin
          cmd_o.op = vdm_pkg::CMD_NORM;
        end
      end
      S_SQRT_A: begin
        cmd_o.op = vdm_pkg::CMD_SQRT_STEP;
        if (sts_i.iter_last) state_d = S_SAVE_A;
      end
      S_SAVE_A: begin
        cmd_o.op = vdm_pkg::CMD_SAVE_A;
        state_d  = S_NORM_B;
      end
      S_SQRT_B: begin
        cmd_o.op = vdm_pkg::CMD_SQRT_STEP;
        if (sts_i.iter_last) state_d = S_SAVE_B;
      end
      S_SAVE_B: begin
        cmd_o.op = vdm_pkg::CMD_SAVE_B;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = vdm_pkg::CMD_MUL;
        state_d  = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.op = vdm_pkg::CMD_DIV_INIT;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = vdm_pkg::CMD_DIV_STEP;
        if (sts_i.iter_last) begin
          kind_d  = vdm_pkg::CMD_RES_COS;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op = kind_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= vdm_pkg::CMD_NONE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

@@ sv/vector_distance_metric.sv @@
// Top level of the vector distance block: joins the sequencer and datapath.
// Depends on vdm_pkg, vdm_ctrl and vdm_datapath.
//
// Element pairs (signed Q4.12) are taken one per clock while the block is
// collecting a vector; each pair feeds four registered multipliers whose
// products are summed into 48-bit accumulators in the next cycle. Pairs beyond
// MaxDim are ignored, but their last mark still closes the vector. Once the
// last pair is in, the block stops taking requests while one shared
// iterative unit finishes the metric: Euclidean mode runs a 32-step square
// root; cosine mode normalises each norm by two bits a cycle, takes two
// 32-step roots, one multiply and a 20-step restoring divide. A zero norm
// or an unsupported mode skips the iterative unit. The last step waits while
// an earlier result is still held, stalled, in the output register. The
// result (unsigned Q16.16, all ones for infinity) sits in that register, so
// the next vector may start while it waits to be taken. metric_mode is read
// in the dispatch state, after the vector closes.
module vector_distance_metric #(
  parameter int unsigned MaxDim = vdm_pkg::MaxDimDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [vdm_pkg::ElemBits-1:0] elem_a_i,
  input  logic signed [vdm_pkg::ElemBits-1:0] elem_b_i,
  input  logic                                last_elem_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [vdm_pkg::DistBits-1:0]        distance_o,
  output logic [1:0]                          status_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_data_i
);

  vdm_pkg::cmd_t cmd;
  vdm_pkg::sts_t sts;

  // sequencer: owns the input handshake
  vdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_elem_i (last_elem_i),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: accumulators, root/divide unit and result register
  vdm_datapath #(
    .MaxDim (MaxDim)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .elem_a_i    (elem_a_i),
    .elem_b_i    (elem_b_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .distance_o  (distance_o),
    .status_o    (status_o)
  );

endmodule

@@ sv/vdm_checker.sv @@
// Port-level checks of the vector distance block, bound to the top level.
// Depends on vdm_pkg.
module vdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] distance_o,
  input logic [1:0]  status_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o) && $stable(status_o))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status");

  a_zero_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == vdm_pkg::ST_ZERO |-> distance_o == '1)
    else $error("zero vector without infinity");

  a_bad_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == vdm_pkg::ST_BAD |-> distance_o == '1)
    else $error("unsupported mode without infinity");

endmodule

bind vector_distance_metric vdm_checker u_vdm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .distance_o  (distance_o),
  .status_o    (status_o)
);

@@ sim/vdm_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard of the vector distance block: accumulates element pairs,
// predicts the distance of each closed vector and compares results.
// Depends on vdm_pkg.
module vdm_scoreboard (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [vdm_pkg::ElemBits-1:0] elem_a_i,
  input  logic signed [vdm_pkg::ElemBits-1:0] elem_b_i,
  input  logic                                last_elem_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [vdm_pkg::DistBits-1:0]        distance_i,
  input  logic [1:0]                          status_i,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  result_count_o
);

  localparam logic [47:0] AccMask = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] distance;
    logic [1:0]  status;
  } dist_res_t;

  dist_res_t   expected_q[$];
  logic [47:0] sq_diff_acc, dot_acc, norm_a_acc, norm_b_acc;
  int          pair_count;
  logic [1:0]  mode_reg;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= r + bit_v) begin
        x = x - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  function automatic dist_res_t predict_distance();
    dist_res_t   res;
    logic [63:0] x, r, ra, rb, den, mag, q;
    int          ka, kb, s;
    logic        neg;
    res.status = vdm_pkg::ST_OK;
    if (mode_reg == vdm_pkg::MODE_L2) begin
      x = {16'd0, sq_diff_acc} << 8;
      r = floor_sqrt(x);
      if (x - r * r > r) r = r + 1;
      res.distance = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    end else if (mode_reg == vdm_pkg::MODE_COS) begin
      if (norm_a_acc == 0 || norm_b_acc == 0) begin
        res.distance = '1;
        res.status   = vdm_pkg::ST_ZERO;
      end else begin
        // normalise each norm into [2^60, 2^62) by even shifts
        x = {16'd0, norm_a_acc}; ka = 0;
        while (x < (64'd1 << 60)) begin x = x << 2; ka++; end
        ra = floor_sqrt(x);
        x = {16'd0, norm_b_acc}; kb = 0;
        while (x < (64'd1 << 60)) begin x = x << 2; kb++; end
        rb = floor_sqrt(x);
        den = (ra * rb) >> 16;
        neg = dot_acc[47];
        mag = {16'd0, neg ? ((~dot_acc + 48'd1) & AccMask) : dot_acc};
        s = ka + kb;
        if (mag > ((64'd1 << 62) >> s)) begin
          q = 64'd65536;
        end else begin
          q = ((mag << s) + den / 2) / den;
          if (q > 64'd65536) q = 64'd65536;
        end
        x = neg ? 64'd65536 + q : 64'd65536 - q;
        res.distance = x[31:0];
      end
    end else begin
      res.distance = '1;
      res.status   = vdm_pkg::ST_BAD;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [47:0] a, b, d;
    dist_res_t          got, want;
    if (!rst_ni) begin
      sq_diff_acc = 0; dot_acc = 0; norm_a_acc = 0; norm_b_acc = 0;
      pair_count = 0; mode_reg = vdm_pkg::MODE_L2;
      expected_q.delete();
      fail_count_o = 0; result_count_o = 0;
    end else begin
      if (cfg_we_i) mode_reg = cfg_data_i;
      // accumulate an accepted request, then close the vector on its mark
      if (in_valid_i && !in_stall_i) begin
        if (pair_count < vdm_pkg::MaxDimDef) begin
          a = elem_a_i; b = elem_b_i; d = a - b;
          sq_diff_acc = (sq_diff_acc + d * d) & AccMask;
          dot_acc     = (dot_acc + a * b) & AccMask;
          norm_a_acc  = (norm_a_acc + a * a) & AccMask;
          norm_b_acc  = (norm_b_acc + b * b) & AccMask;
          pair_count++;
        end
        if (last_elem_i) begin
          expected_q.push_back(predict_distance());
          sq_diff_acc = 0; dot_acc = 0; norm_a_acc = 0; norm_b_acc = 0;
          pair_count = 0;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        got.distance = distance_i;
        got.status   = status_i;
        result_count_o++;
        if (expected_q.size() == 0) begin
          $error("unexpected result: distance %h status %0d", distance_i, status_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.distance !== want.distance) begin
            $error("distance: expected %h, actual %h", want.distance, got.distance);
            fail_count_o++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_q.size();
  end
endmodule

@@ sim/vector_distance_metric_tb.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for the vector distance block.
// Depends on vdm_pkg, vector_distance_metric and vdm_scoreboard.
module vector_distance_metric_tb;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic signed [vdm_pkg::ElemBits-1:0] elem_a_i = '0;
  logic signed [vdm_pkg::ElemBits-1:0] elem_b_i = '0;
  logic                                last_elem_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [vdm_pkg::DistBits-1:0]        distance_o;
  logic [1:0]                          status_o;
  logic                                cfg_we_i = 1'b0;
  logic [1:0]                          cfg_data_i = vdm_pkg::MODE_L2;

  int fail_count, pending, result_count;
  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  int pair_total;

  // Unsupported mode codes have no name in the package.
  localparam logic [1:0] ModeUnsup2 = 2'd2;
  localparam logic [1:0] ModeUnsup3 = 2'd3;

  vector_distance_metric dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .elem_a_i, .elem_b_i,
    .last_elem_i, .out_valid_o, .out_stall_i, .distance_o, .status_o,
    .cfg_we_i, .cfg_data_i
  );

  vdm_scoreboard u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .elem_a_i, .elem_b_i,
    .last_elem_i, .out_valid_i(out_valid_o), .out_stall_i, .distance_i(distance_o),
    .status_i(status_o), .cfg_we_i, .cfg_data_i, .fail_count_o(fail_count),
    .pending_o(pending), .result_count_o(result_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: stall at random, or hold off completely during a pressure stretch.
  always @(negedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one request and hold it until the block takes it; valid stays up
  // so that the next request can follow straight on.
  task automatic send_pair(input logic [15:0] a, input logic [15:0] b,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    elem_a_i    <= a;
    elem_b_i    <= b;
    last_elem_i <= last;
    pair_total++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Wait until every result is in and the block has settled, then write the mode.
  task automatic set_mode(input logic [1:0] mode);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mode;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Pick an element: mostly small magnitudes, sometimes extremes.
  function automatic logic [15:0] pick_elem();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($urandom);
      default: return 16'($signed($urandom_range(8191)) - 4096);
    endcase
  endfunction

  task automatic send_vector(input int len);
    for (int i = 0; i < len; i++)
      send_pair(pick_elem(), pick_elem(), i == len - 1);
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int vecs);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int v = 0; v < vecs; v++) begin
      if ($urandom_range(7) == 0) set_mode(2'($urandom_range(3)));
      send_vector($urandom_range(1, 12));
    end
  endtask

  initial begin
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0; pair_total = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, zero vectors, opposite and equal vectors in each mode.
    set_mode(vdm_pkg::MODE_L2);
    send_pair(16'h7FFF, 16'h8000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b0);
    send_pair(16'hFFFF, 16'h0001, 1'b1);
    set_mode(vdm_pkg::MODE_COS);
    send_pair(16'h1000, 16'h1000, 1'b1);
    send_pair(16'h1000, 16'hF000, 1'b1);
    send_pair(16'h0000, 16'h1000, 1'b1);
    send_pair(16'h1000, 16'h0000, 1'b1);
    send_pair(16'h7FFF, 16'h8000, 1'b0);
    send_pair(16'h0001, 16'h7FFF, 1'b1);
    send_pair(16'h1000, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h1000, 1'b1);
    set_mode(ModeUnsup2);
    send_pair(16'h5555, 16'hAAAA, 1'b1);
    set_mode(ModeUnsup3);
    send_pair(16'hAAAA, 16'h5555, 1'b1);

    // Random phases across the idling patterns.
    random_phase(0, 0, 25);
    random_phase(84, 0, 20);
    random_phase(0, 84, 20);
    random_phase(11, 11, 25);

    // Pressure: receiver holds off while the sender keeps offering vectors.
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    send_vector(3);
    for (int v = 0; v < 6; v++) send_vector($urandom_range(1, 4));
    in_valid_i <= 1'b0;
    wait (!hold_off);
    @(negedge clk_i);
    random_phase(0, 0, 20);

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("Run covered %0d element pairs and %0d results over all modes,",
             pair_total, result_count);
    $display("extremes, zero norms, a long output hold-off and idle/stall patterns.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
